>>> rtl/vcsd_pkg.sv
// ============================================================================
// vcsd_pkg
// Shared types, codes and tables of the command stream decoder.
// ============================================================================
package vcsd_pkg;

  localparam int PCM_ADDR_BITS = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;

  localparam logic [3:0] DATA_PHASE = 4'd15;
  localparam logic [4:0] LEN_UNKNOWN = 5'h10;

  // Opcodes with behavior of their own
  localparam logic [7:0] OP_WRITE_A     = 8'h50;
  localparam logic [7:0] OP_NOCHIP_A    = 8'h5e;
  localparam logic [7:0] OP_NOCHIP_B    = 8'h5f;
  localparam logic [7:0] OP_WAIT16      = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC   = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL    = 8'h63;
  localparam logic [7:0] OP_WAIT_PRESET = 8'h64;
  localparam logic [7:0] OP_END         = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK  = 8'h67;
  localparam logic [7:0] OP_SEEK        = 8'he0;
  localparam logic [3:0] NIB_SHORT_WAIT = 4'h7;
  localparam logic [3:0] NIB_PCM_WRITE  = 4'h8;

  // Data block types
  localparam logic [7:0] BT_PCM    = 8'h00;
  localparam logic [7:0] BT_ROM_A  = 8'h81;
  localparam logic [7:0] BT_ROM_B  = 8'h88;

  localparam logic [3:0] CHIP_PCM   = 4'd2;
  localparam logic [3:0] CHIP_ROM_A = 4'd5;
  localparam logic [3:0] CHIP_ROM_B = 4'd8;
  localparam logic [8:0] REG_PCM    = 9'h02a;
  localparam logic [8:0] REG_ROM_A  = 9'h108;
  localparam logic [8:0] REG_ROM_B  = 9'h00f;
  localparam logic [3:0] PRE_LAST   = 4'd10;

  localparam logic [15:0] WAIT_NTSC_RST = 16'd735;
  localparam logic [15:0] WAIT_PAL_RST  = 16'd882;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 8'd1;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_WAIT    = 3'd1,
    KIND_END     = 3'd2,
    KIND_RESTART = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OPCODE  = 2'd1,
    ERR_PRESET  = 2'd2,
    ERR_SHORT   = 2'd3
  } err_e;

  typedef struct packed {
    logic        single_v;
    kind_e       kind;
    logic [3:0]  chip;
    logic [8:0]  reg_addr;
    logic [7:0]  data;
    logic        pcm_sel;
    logic [15:0] wait_samples;
    err_e        err;
    logic        pre_v;
    logic        post_v;
    logic        rom_a;
    logic [15:0] s_addr;
    logic [15:0] e_addr;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } dec_out_t;

  typedef struct packed {
    logic [8:0] reg_addr;
    logic [7:0] data;
  } reg_data_t;

  function automatic logic [4:0] operand_len(input logic [7:0] op);
    logic [4:0] len;
    case (op)
      8'h4f, 8'h50, 8'h94:        len = 5'd1;
      8'h61:                      len = 5'd2;
      8'h62, 8'h63, 8'h66:        len = 5'd0;
      8'h64:                      len = 5'd3;
      8'h67:                      len = 5'd6;
      8'h68:                      len = 5'd11;
      8'h90, 8'h91, 8'h95:        len = 5'd4;
      8'h92:                      len = 5'd5;
      8'h93:                      len = 5'd10;
      default: begin
        case (op[7:4])
          4'h3:             len = 5'd1;
          4'h4, 4'h5, 4'ha, 4'hb: len = 5'd2;
          4'h7, 4'h8:       len = 5'd0;
          4'hc, 4'hd:       len = 5'd3;
          4'he, 4'hf:       len = 5'd4;
          default:          len = LEN_UNKNOWN;
        endcase
      end
    endcase
    return len;
  endfunction

  // Bit 4 flags a real chip write opcode
  function automatic logic [4:0] chip_code(input logic [7:0] op);
    logic [4:0] c;
    case (op)
      8'h50:        c = 5'h10;
      8'h51:        c = 5'h11;
      8'h52, 8'h53: c = 5'h12;
      8'h54:        c = 5'h13;
      8'h55:        c = 5'h14;
      8'h56, 8'h57: c = 5'h15;
      8'h5a:        c = 5'h16;
      8'h5b:        c = 5'h17;
      8'h5c:        c = 5'h18;
      8'ha0:        c = 5'h19;
      default:      c = 5'h00;
    endcase
    return c;
  endfunction

  function automatic reg_data_t pre_entry(input logic rom_a, input logic [3:0] sub,
                                          input logic [15:0] s, input logic [15:0] e);
    reg_data_t r;
    r = '0;
    if (rom_a) begin
      case (sub)
        4'd0:    r = '{9'h100, 8'h00};
        4'd1:    r = '{9'h100, 8'h01};
        4'd2:    r = '{9'h101, 8'h00};
        4'd3:    r = '{9'h102, s[7:0]};
        4'd4:    r = '{9'h103, s[15:8]};
        4'd5:    r = '{9'h104, e[7:0]};
        4'd6:    r = '{9'h105, e[15:8]};
        4'd7:    r = '{9'h10c, 8'hff};
        4'd8:    r = '{9'h10d, 8'hff};
        4'd9:    r = '{9'h110, 8'h1f};
        default: r = '{9'h100, 8'h60};
      endcase
    end else begin
      case (sub)
        4'd0:    r = '{9'h007, 8'h00};
        4'd1:    r = '{9'h007, 8'h01};
        4'd2:    r = '{9'h007, 8'h00};
        4'd3:    r = '{9'h004, 8'h78};
        4'd4:    r = '{9'h004, 8'h80};
        4'd5:    r = '{9'h007, 8'h60};
        4'd6:    r = '{9'h008, 8'h00};
        4'd7:    r = '{9'h009, s[7:0]};
        4'd8:    r = '{9'h00a, s[15:8]};
        4'd9:    r = '{9'h00b, e[7:0]};
        default: r = '{9'h00c, e[15:8]};
      endcase
    end
    return r;
  endfunction

  function automatic reg_data_t post_entry(input logic rom_a, input logic [3:0] sub);
    reg_data_t r;
    r = '0;
    if (rom_a) begin
      case (sub)
        4'd0:    r = '{9'h100, 8'h00};
        default: r = '{9'h110, 8'h80};
      endcase
    end else begin
      case (sub)
        4'd0:    r = '{9'h007, 8'h00};
        4'd1:    r = '{9'h004, 8'h78};
        default: r = '{9'h004, 8'h80};
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/vcsd_byte_if.sv
// ============================================================================
// vcsd_byte_if
// Stream byte channel.
// ============================================================================
interface vcsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

>>> rtl/vcsd_res_if.sv
// ============================================================================
// vcsd_res_if
// Result channel.
// ============================================================================
interface vcsd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  chip;
  logic [8:0]  reg_addr;
  logic [7:0]  write_data;
  logic [15:0] wait_samples;
  logic [1:0]  error_code;
  logic        last;
  modport source(output valid, output kind, output chip, output reg_addr,
                 output write_data, output wait_samples, output error_code,
                 output last, input ready);
  modport sink(input valid, input kind, input chip, input reg_addr,
               input write_data, input wait_samples, input error_code,
               input last, output ready);
endinterface

>>> rtl/vcsd_cfg_if.sv
// ============================================================================
// vcsd_cfg_if
// Configuration write channel.
// ============================================================================
interface vcsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/vcsd_decoder.sv
// ============================================================================
// vcsd_decoder
// Parser state, PCM store and per-byte result descriptor.
// ============================================================================
module vcsd_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vcsd_byte_if.sink            in_i,
  vcsd_cfg_if.sink             cfg_i,
  input  logic                 take_ready_i,
  output vcsd_pkg::dec_out_t   dec_o,
  output logic [7:0]           pcm_data_o
);

  localparam int AW = vcsd_pkg::PCM_ADDR_BITS;
  localparam int DEPTH = 1 << AW;

  logic        loop_en_q;
  logic [7:0]  rep_lim_q;
  logic [7:0]  cur_q, cur_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] opw_q, opw_d;
  logic [7:0]  btype_q, btype_d;
  logic [31:0] brem_q, brem_d;
  logic [31:0] rstart_q, rstart_d;
  logic [15:0] w62_q, w62_d, w63_q, w63_d;
  logic [7:0]  loops_q, loops_d;
  logic        halted_q, halted_d;
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rd_q;
  logic        mem_we, rd_en;
  logic        acc;
  vcsd_pkg::desc_t desc;

  assign acc = in_i.valid && take_ready_i;
  assign in_i.ready = take_ready_i;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  len;
    logic [4:0]  cc;
    logic        exec_go;
    logic [7:0]  op;
    logic [31:0] w;
    logic        fail_go;
    vcsd_pkg::err_e fail_code;
    logic [3:0]  idx;
    logic [7:0]  bt;
    logic [31:0] br;
    logic [31:0] rs;
    logic        rom;
    logic [17:0] esum;
    logic [7:0]  lp;
    b = in_i.stream_byte;
    len = '0; cc = '0; exec_go = 1'b0; op = '0; w = '0;
    fail_go = 1'b0; fail_code = vcsd_pkg::ERR_NONE;
    idx = '0; bt = btype_q; br = brem_q; rs = rstart_q; rom = 1'b0;
    esum = '0; lp = '0;
    cur_d = cur_q; cnt_d = cnt_q; opw_d = opw_q; btype_d = btype_q;
    brem_d = brem_q; rstart_d = rstart_q; w62_d = w62_q; w63_d = w63_q;
    loops_d = loops_q; halted_d = halted_q; wptr_d = wptr_q; rptr_d = rptr_q;
    mem_we = 1'b0; rd_en = 1'b0;
    desc = '0;

    if (acc && !halted_q) begin
      if (cnt_q == 4'd0) begin
        len = vcsd_pkg::operand_len(b);
        if (len == vcsd_pkg::LEN_UNKNOWN) begin
          fail_go = 1'b1;
          fail_code = vcsd_pkg::ERR_OPCODE;
        end else if (len == 5'd0) begin
          opw_d = '0;
          exec_go = 1'b1;
          op = b;
          w = '0;
        end else begin
          cur_d = b;
          cnt_d = 4'd1;
          opw_d = '0;
          if (b == vcsd_pkg::OP_DATA_BLOCK) begin
            btype_d = '0;
            brem_d = '0;
            rstart_d = '0;
          end
        end
      end else if (cur_q == vcsd_pkg::OP_DATA_BLOCK) begin
        if (cnt_q != vcsd_pkg::DATA_PHASE) begin
          idx = cnt_q - 4'd1;
          case (idx)
            4'd1:  bt = b;
            4'd2:  br[7:0] = br[7:0] | b;
            4'd3:  br[15:8] = br[15:8] | b;
            4'd4:  br[23:16] = br[23:16] | b;
            4'd5:  br[31:24] = br[31:24] | b;
            4'd10: rs[7:0] = rs[7:0] | b;
            4'd11: rs[15:8] = rs[15:8] | b;
            4'd12: rs[23:16] = rs[23:16] | b;
            4'd13: rs[31:24] = rs[31:24] | b;
            default: ;
          endcase
          cnt_d = cnt_q + 4'd1;
          rom = (bt[7:6] == 2'b10);
          if (idx == 4'd5) begin
            if (rom) begin
              if (br < 32'd8) begin
                fail_go = 1'b1;
                fail_code = vcsd_pkg::ERR_SHORT;
              end else begin
                br = br - 32'd8;
                rs = '0;
              end
            end else begin
              if (bt == vcsd_pkg::BT_PCM) begin
                wptr_d = '0;
                rptr_d = '0;
              end
              cnt_d = (br != 32'd0) ? vcsd_pkg::DATA_PHASE : 4'd0;
            end
          end else if (idx == 4'd13) begin
            esum = rs[17:0] + br[17:0] - 18'd1;
            desc.rom_a = (bt == vcsd_pkg::BT_ROM_A);
            desc.s_addr = rs[17:2];
            desc.e_addr = esum[17:2];
            if (bt == vcsd_pkg::BT_ROM_A || bt == vcsd_pkg::BT_ROM_B) begin
              desc.pre_v = 1'b1;
              desc.post_v = (br == 32'd0);
            end
            if (br == 32'd0) cnt_d = 4'd0;
          end
          btype_d = bt;
          brem_d = br;
          rstart_d = rs;
        end else begin
          br = brem_q - 32'd1;
          brem_d = br;
          desc.rom_a = (btype_q == vcsd_pkg::BT_ROM_A);
          if (btype_q == vcsd_pkg::BT_PCM) begin
            mem_we = 1'b1;
            wptr_d = wptr_q + 1'b1;
          end else if (btype_q == vcsd_pkg::BT_ROM_A) begin
            desc.single_v = 1'b1;
            desc.chip = vcsd_pkg::CHIP_ROM_A;
            desc.reg_addr = vcsd_pkg::REG_ROM_A;
            desc.data = b;
          end else if (btype_q == vcsd_pkg::BT_ROM_B) begin
            desc.single_v = 1'b1;
            desc.chip = vcsd_pkg::CHIP_ROM_B;
            desc.reg_addr = vcsd_pkg::REG_ROM_B;
            desc.data = b;
          end
          if (br == 32'd0) begin
            cnt_d = 4'd0;
            desc.post_v = (btype_q == vcsd_pkg::BT_ROM_A) ||
                          (btype_q == vcsd_pkg::BT_ROM_B);
          end
        end
      end else begin
        idx = cnt_q - 4'd1;
        w = opw_q;
        case (idx)
          4'd0: w[7:0] = w[7:0] | b;
          4'd1: w[15:8] = w[15:8] | b;
          4'd2: w[23:16] = w[23:16] | b;
          4'd3: w[31:24] = w[31:24] | b;
          default: ;
        endcase
        opw_d = w;
        cnt_d = cnt_q + 4'd1;
        len = vcsd_pkg::operand_len(cur_q);
        if ({1'b0, cnt_q} >= len) begin
          cnt_d = 4'd0;
          exec_go = 1'b1;
          op = cur_q;
        end
      end
    end

    // Run the command once its operands are in
    if (exec_go) begin
      cc = vcsd_pkg::chip_code(op);
      if (cc[4]) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WRITE;
        desc.chip = cc[3:0];
        desc.wait_samples = 16'd1;
        if (op == vcsd_pkg::OP_WRITE_A) begin
          desc.data = w[7:0];
        end else begin
          desc.data = w[15:8];
          desc.reg_addr = {((op == 8'h52) || (op == 8'h53) || (op == 8'h56) ||
                            (op == 8'h57)) & op[0], w[7:0]};
        end
      end else if (op == vcsd_pkg::OP_NOCHIP_A || op == vcsd_pkg::OP_NOCHIP_B) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WAIT;
        desc.wait_samples = 16'd1;
      end else if (op == vcsd_pkg::OP_WAIT16) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WAIT;
        desc.wait_samples = w[15:0];
      end else if (op == vcsd_pkg::OP_WAIT_NTSC) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WAIT;
        desc.wait_samples = w62_q;
      end else if (op == vcsd_pkg::OP_WAIT_PAL) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WAIT;
        desc.wait_samples = w63_q;
      end else if (op == vcsd_pkg::OP_WAIT_PRESET) begin
        if (w[7:0] == vcsd_pkg::OP_WAIT_NTSC) begin
          w62_d = w[23:8];
        end else if (w[7:0] == vcsd_pkg::OP_WAIT_PAL) begin
          w63_d = w[23:8];
        end else begin
          fail_go = 1'b1;
          fail_code = vcsd_pkg::ERR_PRESET;
        end
      end else if (op == vcsd_pkg::OP_END) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_RESTART;
        lp = loops_q + 8'd1;
        if (!loop_en_q) begin
          halted_d = 1'b1;
          desc.kind = vcsd_pkg::KIND_END;
        end else if (rep_lim_q != 8'd0) begin
          loops_d = lp;
          if (lp >= rep_lim_q) begin
            halted_d = 1'b1;
            desc.kind = vcsd_pkg::KIND_END;
          end
        end
      end else if (op[7:4] == vcsd_pkg::NIB_SHORT_WAIT) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WAIT;
        desc.wait_samples = {12'd0, op[3:0]} + 16'd1;
      end else if (op[7:4] == vcsd_pkg::NIB_PCM_WRITE) begin
        desc.single_v = 1'b1;
        desc.kind = vcsd_pkg::KIND_WRITE;
        desc.chip = vcsd_pkg::CHIP_PCM;
        desc.reg_addr = vcsd_pkg::REG_PCM;
        desc.pcm_sel = 1'b1;
        desc.wait_samples = {12'd0, op[3:0]};
        rd_en = 1'b1;
        rptr_d = rptr_q + 1'b1;
      end else if (op == vcsd_pkg::OP_SEEK) begin
        rptr_d = w[AW-1:0];
      end
    end

    // Error result: halt and drop everything after
    if (fail_go) begin
      halted_d = 1'b1;
      cnt_d = 4'd0;
      desc = '0;
      desc.single_v = 1'b1;
      desc.kind = vcsd_pkg::KIND_ERROR;
      desc.err = fail_code;
    end
  end

  assign dec_o.valid = acc && (desc.single_v || desc.pre_v || desc.post_v);
  assign dec_o.desc = desc;
  assign pcm_data_o = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q <= 1'b0;
      rep_lim_q <= '0;
      cur_q <= '0;
      cnt_q <= '0;
      opw_q <= '0;
      btype_q <= '0;
      brem_q <= '0;
      rstart_q <= '0;
      w62_q <= vcsd_pkg::WAIT_NTSC_RST;
      w63_q <= vcsd_pkg::WAIT_PAL_RST;
      loops_q <= '0;
      halted_q <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == vcsd_pkg::CFG_LOOP_ENABLED) loop_en_q <= cfg_i.data[0];
        if (cfg_i.index == vcsd_pkg::CFG_REPEAT_LIMIT) rep_lim_q <= cfg_i.data;
      end
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      opw_q <= opw_d;
      btype_q <= btype_d;
      brem_q <= brem_d;
      rstart_q <= rstart_d;
      w62_q <= w62_d;
      w63_q <= w63_d;
      loops_q <= loops_d;
      halted_q <= halted_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // PCM store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wptr_q] <= in_i.stream_byte;
    if (rd_en) rd_q <= mem[rptr_q];
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt released");
  a_data_phase_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == vcsd_pkg::DATA_PHASE) |-> (cur_q == vcsd_pkg::OP_DATA_BLOCK))
    else $error("data phase outside a data block");
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && halted_q) |-> !dec_o.valid) else $error("result after halt");
`endif

endmodule

>>> rtl/vcsd_emitter.sv
// ============================================================================
// vcsd_emitter
// Holds one descriptor and plays out its results, one per transaction.
// ============================================================================
module vcsd_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vcsd_pkg::dec_out_t dec_i,
  input  logic [7:0]         pcm_data_i,
  output logic               take_ready_o,
  vcsd_res_if.source         res_o
);

  localparam logic [1:0] PH_SINGLE = 2'd0;
  localparam logic [1:0] PH_PRE    = 2'd1;
  localparam logic [1:0] PH_POST   = 2'd2;

  logic            busy_q, busy_d;
  vcsd_pkg::desc_t desc_q, desc_d;
  logic [1:0]      phase_q, phase_d;
  logic [3:0]      sub_q, sub_d;
  logic            last_now;
  logic            out_acc;
  vcsd_pkg::reg_data_t rd_pre, rd_post;

  assign rd_pre  = vcsd_pkg::pre_entry(desc_q.rom_a, sub_q, desc_q.s_addr, desc_q.e_addr);
  assign rd_post = vcsd_pkg::post_entry(desc_q.rom_a, sub_q);

  always_comb begin
    last_now = 1'b0;
    res_o.kind = vcsd_pkg::KIND_WRITE;
    res_o.chip = desc_q.rom_a ? vcsd_pkg::CHIP_ROM_A : vcsd_pkg::CHIP_ROM_B;
    res_o.reg_addr = '0;
    res_o.write_data = '0;
    res_o.wait_samples = '0;
    res_o.error_code = vcsd_pkg::ERR_NONE;
    unique case (phase_q)
      PH_SINGLE: begin
        last_now = !desc_q.pre_v && !desc_q.post_v;
        res_o.kind = desc_q.kind;
        res_o.chip = desc_q.chip;
        res_o.reg_addr = desc_q.reg_addr;
        res_o.write_data = desc_q.pcm_sel ? pcm_data_i : desc_q.data;
        res_o.wait_samples = desc_q.wait_samples;
        res_o.error_code = desc_q.err;
      end
      PH_PRE: begin
        last_now = (sub_q == vcsd_pkg::PRE_LAST) && !desc_q.post_v;
        res_o.reg_addr = rd_pre.reg_addr;
        res_o.write_data = rd_pre.data;
      end
      PH_POST: begin
        last_now = (sub_q == (desc_q.rom_a ? 4'd1 : 4'd2));
        res_o.reg_addr = rd_post.reg_addr;
        res_o.write_data = rd_post.data;
      end
      default: ;
    endcase
  end

  assign res_o.valid = busy_q;
  assign res_o.last = last_now;
  assign out_acc = busy_q && res_o.ready;
  assign take_ready_o = !busy_q || (res_o.ready && last_now);

  always_comb begin
    busy_d = busy_q;
    desc_d = desc_q;
    phase_d = phase_q;
    sub_d = sub_q;
    if (out_acc) begin
      if (last_now) begin
        busy_d = 1'b0;
      end else if (phase_q == PH_SINGLE) begin
        phase_d = desc_q.pre_v ? PH_PRE : PH_POST;
        sub_d = '0;
      end else if (phase_q == PH_PRE && sub_q == vcsd_pkg::PRE_LAST) begin
        phase_d = PH_POST;
        sub_d = '0;
      end else begin
        sub_d = sub_q + 4'd1;
      end
    end
    if (dec_i.valid) begin
      busy_d = 1'b1;
      desc_d = dec_i.desc;
      phase_d = dec_i.desc.single_v ? PH_SINGLE :
                (dec_i.desc.pre_v ? PH_PRE : PH_POST);
      sub_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      phase_q <= PH_SINGLE;
      sub_q <= '0;
    end else begin
      busy_q <= busy_d;
      phase_q <= phase_d;
      sub_q <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_i.valid |-> (!busy_q || (out_acc && last_now)))
    else $error("descriptor overwritten");
  a_post_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == PH_POST) |-> desc_q.post_v)
    else $error("postamble without request");
  a_pre_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && phase_q == PH_PRE) |-> (desc_q.pre_v && sub_q <= vcsd_pkg::PRE_LAST))
    else $error("preamble index out of range");
`endif

endmodule

>>> rtl/vcsd_command_stream_decoder.sv
// ============================================================================
// vgm_command_stream_decoder
// Byte-serial sound-chip command stream decoder, top level.
// ============================================================================
// Takes one stream byte per cycle on in_i while the emitter can take it, and
// delivers register writes, waits, loop/end markers and errors on res_o, with
// last set on the final result of each byte. The emitter holds one result
// register, so the next byte is taken in the same cycle that the previous
// byte's last result transaction completes. A ROM data block header byte can
// cause up to 14 results (preamble plus postamble); those leave one per cycle
// while res_o is ready and stall the input until the last one is taken. PCM
// bytes are kept in a 2^PCM_ADDR_BITS byte store with a registered read.
// After an end or an error every byte is taken and dropped until reset.
// Configuration writes on cfg_i are always accepted and act at once; index 0
// is the loop enable, index 1 the repeat limit.
// ============================================================================
module vgm_command_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  vcsd_byte_if.sink  in_i,
  vcsd_cfg_if.sink   cfg_i,
  vcsd_res_if.source res_o
);

  vcsd_pkg::dec_out_t dec;
  logic [7:0]         pcm_data;
  logic               take_ready;

  // Parse bytes, track block state, build the result descriptor
  vcsd_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .take_ready_i (take_ready),
    .dec_o        (dec),
    .pcm_data_o   (pcm_data)
  );

  // Hold the descriptor and advance through its results
  vcsd_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dec_i        (dec),
    .pcm_data_i   (pcm_data),
    .take_ready_o (take_ready),
    .res_o        (res_o)
  );

endmodule

>>> tb/tb_vgm_command_stream_decoder.sv
// ============================================================================
// tb_vgm_command_stream_decoder
// Self-checking bench for the byte-serial command stream decoder.
// ============================================================================
// Every stream byte runs through a behavioral decoder in the bench as it is
// sent. That decoder queues the results the byte must cause. A monitor
// compares each result transaction, field by field, against the oldest
// queued result. A short table of directed bytes runs first, then random
// well-formed commands, under three idling profiles and several register
// settings. The run ends on one halting command, then a few dropped bytes.
// ============================================================================
module tb_vgm_command_stream_decoder;
  import vcsd_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  chip;
    logic [8:0]  reg_addr;
    logic [7:0]  wdata;
    logic [15:0] wait_s;
    logic [1:0]  err;
    logic        last;
  } res_t;

  typedef struct {
    logic [7:0]  b;
    bit          chk;
    logic [2:0]  k;
    logic [15:0] w;
  } dir_row_t;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;

  vcsd_byte_if in_if();
  vcsd_cfg_if  cfg_if();
  vcsd_res_if  res_if();

  vgm_command_stream_decoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  // Results still owed by the block, oldest first
  res_t due_results[$];
  res_t new_results[$];

  int src_idle;
  int snk_idle;
  int errs;
  int stall_cycles;

  // Decoder state as the bench sees it
  logic        cfg_loop;
  logic [7:0]  cfg_limit;
  logic [7:0]  op_cur;
  logic [3:0]  byte_cnt;
  logic [31:0] opnd;
  logic [7:0]  blk_type;
  logic [31:0] blk_rem;
  logic [31:0] rom_start;
  logic [15:0] preset_62;
  logic [15:0] preset_63;
  logic [7:0]  loops;
  bit          halted;
  logic [7:0]  pcm_mem [65536];
  bit          pcm_ok [65536];
  logic [15:0] wr_ptr;
  logic [15:0] rd_ptr;
  int          pcm_hi;

  logic [7:0] chip_ops [13] = '{8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56,
                                8'h57, 8'h5a, 8'h5b, 8'h5c, 8'ha0, 8'h52};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------
  function automatic int cmd_len(logic [7:0] op);
    case (op)
      8'h4f, 8'h50, 8'h94: return 1;
      8'h61:               return 2;
      8'h62, 8'h63, 8'h66: return 0;
      8'h64:               return 3;
      8'h67:               return 6;
      8'h68:               return 11;
      8'h90, 8'h91, 8'h95: return 4;
      8'h92:               return 5;
      8'h93:               return 10;
      default: ;
    endcase
    case (op[7:4])
      4'h3:                   return 1;
      4'h4, 4'h5, 4'ha, 4'hb: return 2;
      4'h7, 4'h8:             return 0;
      4'hc, 4'hd:             return 3;
      4'he, 4'hf:             return 4;
      default:                return -1;
    endcase
  endfunction

  function automatic int chip_of(logic [7:0] op);
    case (op)
      8'h50:        return 0;
      8'h51:        return 1;
      8'h52, 8'h53: return 2;
      8'h54:        return 3;
      8'h55:        return 4;
      8'h56, 8'h57: return 5;
      8'h5a:        return 6;
      8'h5b:        return 7;
      8'h5c:        return 8;
      8'ha0:        return 9;
      default:      return -1;
    endcase
  endfunction

  task automatic emit(logic [2:0] k, logic [3:0] c, logic [8:0] ra, logic [7:0] d,
                      logic [15:0] w, logic [1:0] e);
    res_t r;
    r = '{k, c, ra, d, w, e, 1'b0};
    new_results.push_back(r);
  endtask

  task automatic raise_err(logic [1:0] code);
    halted = 1'b1;
    byte_cnt = '0;
    emit(KIND_ERROR, 4'd0, 9'd0, 8'd0, 16'd0, code);
  endtask

  task automatic run_cmd(logic [7:0] op);
    logic [7:0]  aa;
    logic [7:0]  dd;
    logic [8:0]  ra;
    logic [15:0] v;
    int          c;
    aa = opnd[7:0];
    dd = opnd[15:8];
    v  = opnd[23:8];
    c  = chip_of(op);
    if (op == OP_WRITE_A) begin
      emit(KIND_WRITE, 4'd0, 9'd0, aa, 16'd1, ERR_NONE);
    end else if (c >= 0) begin
      ra = {1'b0, aa};
      if (op == 8'h52 || op == 8'h53 || op == 8'h56 || op == 8'h57) ra[8] = op[0];
      emit(KIND_WRITE, c[3:0], ra, dd, 16'd1, ERR_NONE);
    end else if (op == OP_NOCHIP_A || op == OP_NOCHIP_B) begin
      emit(KIND_WAIT, 4'd0, 9'd0, 8'd0, 16'd1, ERR_NONE);
    end else if (op == OP_WAIT16) begin
      emit(KIND_WAIT, 4'd0, 9'd0, 8'd0, opnd[15:0], ERR_NONE);
    end else if (op == OP_WAIT_NTSC) begin
      emit(KIND_WAIT, 4'd0, 9'd0, 8'd0, preset_62, ERR_NONE);
    end else if (op == OP_WAIT_PAL) begin
      emit(KIND_WAIT, 4'd0, 9'd0, 8'd0, preset_63, ERR_NONE);
    end else if (op == OP_WAIT_PRESET) begin
      if (aa == 8'h62) preset_62 = v;
      else if (aa == 8'h63) preset_63 = v;
      else raise_err(ERR_PRESET);
    end else if (op == OP_END) begin
      // Count passes only when a limit is set; reaching it stops playback
      if (cfg_loop && cfg_limit != 0) loops = loops + 8'd1;
      if (!cfg_loop || (cfg_limit != 0 && loops >= cfg_limit)) begin
        halted = 1'b1;
        emit(KIND_END, 4'd0, 9'd0, 8'd0, 16'd0, ERR_NONE);
      end else begin
        emit(KIND_RESTART, 4'd0, 9'd0, 8'd0, 16'd0, ERR_NONE);
      end
    end else if (op[7:4] == NIB_SHORT_WAIT) begin
      emit(KIND_WAIT, 4'd0, 9'd0, 8'd0, {12'd0, op[3:0]} + 16'd1, ERR_NONE);
    end else if (op[7:4] == NIB_PCM_WRITE) begin
      emit(KIND_WRITE, CHIP_PCM, REG_PCM, pcm_mem[rd_ptr], {12'd0, op[3:0]}, ERR_NONE);
      rd_ptr = rd_ptr + 16'd1;
    end else if (op == OP_SEEK) begin
      rd_ptr = opnd[15:0];
    end
  endtask

  task automatic rom_preamble();
    logic [31:0] s;
    logic [31:0] e;
    logic [8:0]  ra [11];
    logic [7:0]  d [11];
    s = rom_start >> 2;
    e = (rom_start + blk_rem - 32'd1) >> 2;
    if (blk_type == BT_ROM_A) begin
      ra = '{9'h100, 9'h100, 9'h101, 9'h102, 9'h103, 9'h104, 9'h105, 9'h10c, 9'h10d,
             9'h110, 9'h100};
      d  = '{8'h00, 8'h01, 8'h00, s[7:0], s[15:8], e[7:0], e[15:8], 8'hff, 8'hff,
             8'h1f, 8'h60};
      for (int i = 0; i < 11; i++) emit(KIND_WRITE, CHIP_ROM_A, ra[i], d[i], 16'd0, ERR_NONE);
    end else if (blk_type == BT_ROM_B) begin
      ra = '{9'h007, 9'h007, 9'h007, 9'h004, 9'h004, 9'h007, 9'h008, 9'h009, 9'h00a,
             9'h00b, 9'h00c};
      d  = '{8'h00, 8'h01, 8'h00, 8'h78, 8'h80, 8'h60, 8'h00, s[7:0], s[15:8],
             e[7:0], e[15:8]};
      for (int i = 0; i < 11; i++) emit(KIND_WRITE, CHIP_ROM_B, ra[i], d[i], 16'd0, ERR_NONE);
    end
  endtask

  task automatic rom_postamble();
    if (blk_type == BT_ROM_A) begin
      emit(KIND_WRITE, CHIP_ROM_A, 9'h100, 8'h00, 16'd0, ERR_NONE);
      emit(KIND_WRITE, CHIP_ROM_A, 9'h110, 8'h80, 16'd0, ERR_NONE);
    end else if (blk_type == BT_ROM_B) begin
      emit(KIND_WRITE, CHIP_ROM_B, 9'h007, 8'h00, 16'd0, ERR_NONE);
      emit(KIND_WRITE, CHIP_ROM_B, 9'h004, 8'h78, 16'd0, ERR_NONE);
      emit(KIND_WRITE, CHIP_ROM_B, 9'h004, 8'h80, 16'd0, ERR_NONE);
    end
  endtask

  task automatic block_byte(logic [7:0] b);
    int idx;
    bit rom;
    if (byte_cnt < DATA_PHASE) begin
      idx = int'(byte_cnt) - 1;
      if (idx == 1) blk_type = b;
      else if (idx >= 2 && idx <= 5) blk_rem[8*(idx-2) +: 8] = b;
      else if (idx >= 10 && idx <= 13) rom_start[8*(idx-10) +: 8] = b;
      byte_cnt = byte_cnt + 4'd1;
      rom = blk_type >= 8'h80 && blk_type <= 8'hbf;
      if (idx == 5) begin
        if (rom) begin
          if (blk_rem < 32'd8) begin
            raise_err(ERR_SHORT);
          end else begin
            blk_rem = blk_rem - 32'd8;
            rom_start = '0;
          end
        end else begin
          if (blk_type == BT_PCM) begin
            wr_ptr = '0;
            rd_ptr = '0;
          end
          byte_cnt = (blk_rem != 0) ? DATA_PHASE : 4'd0;
        end
      end else if (idx == 13) begin
        rom_preamble();
        if (blk_rem == 0) begin
          rom_postamble();
          byte_cnt = '0;
        end
      end
    end else begin
      blk_rem = blk_rem - 32'd1;
      if (blk_type == BT_PCM) begin
        pcm_mem[wr_ptr] = b;
        pcm_ok[wr_ptr] = 1'b1;
        if (int'(wr_ptr) > pcm_hi) pcm_hi = int'(wr_ptr);
        wr_ptr = wr_ptr + 16'd1;
      end else if (blk_type == BT_ROM_A) begin
        emit(KIND_WRITE, CHIP_ROM_A, REG_ROM_A, b, 16'd0, ERR_NONE);
      end else if (blk_type == BT_ROM_B) begin
        emit(KIND_WRITE, CHIP_ROM_B, REG_ROM_B, b, 16'd0, ERR_NONE);
      end
      if (blk_rem == 0) begin
        rom_postamble();
        byte_cnt = '0;
      end
    end
  endtask

  // Work out what one stream byte causes; leaves the results in new_results
  task automatic decode_byte(logic [7:0] b);
    int len;
    int idx;
    new_results.delete();
    if (!halted) begin
      if (byte_cnt == 0) begin
        len = cmd_len(b);
        if (len < 0) begin
          raise_err(ERR_OPCODE);
        end else if (len == 0) begin
          opnd = '0;
          run_cmd(b);
        end else begin
          op_cur = b;
          byte_cnt = 4'd1;
          opnd = '0;
          if (b == OP_DATA_BLOCK) begin
            blk_type = '0;
            blk_rem = '0;
            rom_start = '0;
          end
        end
      end else if (op_cur == OP_DATA_BLOCK) begin
        block_byte(b);
      end else begin
        idx = int'(byte_cnt) - 1;
        if (idx < 4) opnd[8*idx +: 8] = b;
        byte_cnt = byte_cnt + 4'd1;
        if (int'(byte_cnt) - 1 >= cmd_len(op_cur)) begin
          byte_cnt = '0;
          run_cmd(op_cur);
        end
      end
    end
    if (new_results.size() > 0) new_results[new_results.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Queue what the byte causes, then hold it on the channel until taken.
  // A typed row replaces the decoder's answer with a single known result.
  task automatic send_byte(logic [7:0] b, bit chk = 0, logic [2:0] k = 3'd0,
                           logic [15:0] w = 16'd0);
    res_t r;
    decode_byte(b);
    if (chk) begin
      r = '{k, 4'd0, 9'd0, 8'd0, w, ERR_NONE, 1'b1};
      due_results.push_back(r);
    end else begin
      foreach (new_results[i]) due_results.push_back(new_results[i]);
    end
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.stream_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_rand(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_LOOP_ENABLED) cfg_loop = val[0];
    else if (idx == CFG_REPEAT_LIMIT) cfg_limit = val;
    @(posedge clk);
  endtask

  // Drop valid, wait for every owed result, then give the block time to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Aim the read pointer at stored PCM data, if there is any
  task automatic seek_stored();
    logic [15:0] off;
    off = 16'($urandom_range(0, pcm_hi));
    send_byte(OP_SEEK);
    send_byte(off[7:0]);
    send_byte(off[15:8]);
    send_rand(2);
  endtask

  task automatic data_block(logic [7:0] t, int sz);
    send_byte(OP_DATA_BLOCK);
    send_byte(8'h66);
    send_byte(t);
    send_byte(8'(sz));
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  // One random well-formed command
  task automatic gen_cmd(bit allow_end);
    logic [7:0] op;
    int         sz;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        op = chip_ops[$urandom_range(0, 12)];
        send_byte(op);
        send_rand(op == OP_WRITE_A ? 1 : 2);
      end
      4: begin
        send_byte(OP_WAIT16);
        send_rand(2);
      end
      5: send_byte($urandom_range(0, 1) ? OP_WAIT_NTSC : OP_WAIT_PAL);
      6: send_byte({NIB_SHORT_WAIT, 4'($urandom_range(0, 15))});
      7: begin
        send_byte(OP_WAIT_PRESET);
        send_byte($urandom_range(0, 1) ? 8'h62 : 8'h63);
        send_rand(2);
      end
      8, 9, 10: begin
        // Read only entries that hold stored data
        if (pcm_ok[rd_ptr] && $urandom_range(0, 3) != 0)
          send_byte({NIB_PCM_WRITE, 4'($urandom_range(0, 15))});
        else if (pcm_hi >= 0) seek_stored();
        else send_byte(OP_WAIT_NTSC);
      end
      11, 12: begin
        sz = $urandom_range(0, 12);
        data_block(BT_PCM, sz);
        send_rand(sz);
      end
      13, 14: begin
        case ($urandom_range(0, 4))
          0, 1:    op = BT_ROM_A;
          2, 3:    op = BT_ROM_B;
          default: op = 8'($urandom_range(8'h80, 8'hbf));
        endcase
        sz = $urandom_range(8, 16);
        data_block(op, sz);
        send_rand(sz);
      end
      15: begin
        do op = 8'($urandom_range(1, 255)); while (op >= 8'h80 && op <= 8'hbf);
        sz = $urandom_range(0, 6);
        data_block(op, sz);
        send_rand(sz);
      end
      16: begin
        send_byte($urandom_range(0, 1) ? OP_NOCHIP_A : OP_NOCHIP_B);
        send_rand(2);
      end
      17: send_byte(allow_end ? OP_END : OP_WAIT_PAL);
      default: begin
        // Commands the block takes and drops
        case ($urandom_range(0, 4))
          0: op = 8'($urandom_range(8'h30, 8'h4f));
          1: begin
            case ($urandom_range(0, 3))
              0:       op = 8'h58;
              1:       op = 8'h59;
              2:       op = 8'h5d;
              default: op = 8'h68;
            endcase
          end
          2: op = 8'($urandom_range(8'h90, 8'h95));
          3: op = 8'($urandom_range(8'ha1, 8'hdf));
          default: op = 8'($urandom_range(8'he1, 8'hff));
        endcase
        send_byte(op);
        send_rand(cmd_len(op));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: kind %0d chip %0d reg %h data %h wait %0d err %0d",
                     res_if.kind, res_if.chip, res_if.reg_addr, res_if.write_data,
                     res_if.wait_samples, res_if.error_code);
        end else begin
          exp_r = due_results.pop_front();
          if (res_if.kind !== exp_r.kind || res_if.chip !== exp_r.chip ||
              res_if.reg_addr !== exp_r.reg_addr || res_if.write_data !== exp_r.wdata ||
              res_if.wait_samples !== exp_r.wait_s || res_if.error_code !== exp_r.err ||
              res_if.last !== exp_r.last) begin
            errs++;
            if (errs <= 10)
              $display({"mismatch: exp kind %0d chip %0d reg %h data %h wait %0d err %0d ",
                        "last %0d / got %0d %0d %h %h %0d %0d %0d"},
                       exp_r.kind, exp_r.chip, exp_r.reg_addr, exp_r.wdata, exp_r.wait_s,
                       exp_r.err, exp_r.last, res_if.kind, res_if.chip, res_if.reg_addr,
                       res_if.write_data, res_if.wait_samples, res_if.error_code,
                       res_if.last);
          end
        end
      end
      if ((res_if.valid && res_if.ready) || (in_if.valid && in_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_vgm_command_stream_decoder: done, errors");
          $finish;
        end
      end
    end
    res_if.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Typed rows: waits after reset, extremes and the loop restart
  dir_row_t dir_tab [] = '{
    '{8'h62, 1, KIND_WAIT, 16'd735}, '{8'h63, 1, KIND_WAIT, 16'd882},
    '{8'h70, 1, KIND_WAIT, 16'd1},   '{8'h7f, 1, KIND_WAIT, 16'd16},
    '{8'h61, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 1, KIND_WAIT, 16'hffff},
    '{8'h61, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 1, KIND_WAIT, 16'd0},
    '{8'h5e, 0, 0, 0}, '{8'ha5, 0, 0, 0}, '{8'h5a, 1, KIND_WAIT, 16'd1},
    '{8'h5f, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'hff, 1, KIND_WAIT, 16'd1},
    '{8'h64, 0, 0, 0}, '{8'h62, 0, 0, 0}, '{8'h34, 0, 0, 0}, '{8'h12, 0, 0, 0},
    '{8'h62, 0, 0, 0},
    '{8'h64, 0, 0, 0}, '{8'h63, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'h63, 1, KIND_WAIT, 16'hffff},
    '{8'h66, 1, KIND_RESTART, 16'd0},
    '{8'h50, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'h52, 0, 0, 0}, '{8'h80, 0, 0, 0}, '{8'h55, 0, 0, 0},
    '{8'h53, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'ha0, 0, 0, 0}, '{8'h12, 0, 0, 0}, '{8'h34, 0, 0, 0},
    '{8'h30, 0, 0, 0}, '{8'haa, 0, 0, 0},
    // PCM block of three bytes, replayed, then a seek
    '{8'h67, 0, 0, 0}, '{8'h66, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h03, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'ha5, 0, 0, 0}, '{8'h5a, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'h80, 0, 0, 0}, '{8'h8f, 0, 0, 0},
    '{8'he0, 0, 0, 0}, '{8'h01, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'hff, 0, 0, 0}, '{8'h81, 0, 0, 0},
    // ROM block with no payload: preamble and postamble on one byte
    '{8'h67, 0, 0, 0}, '{8'h66, 0, 0, 0}, '{8'h88, 0, 0, 0}, '{8'h08, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'h10, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    // ROM block that ends at the last byte address below 2^32
    '{8'h67, 0, 0, 0}, '{8'h66, 0, 0, 0}, '{8'h81, 0, 0, 0}, '{8'h0a, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h11, 0, 0, 0}, '{8'h22, 0, 0, 0}, '{8'h33, 0, 0, 0}, '{8'h44, 0, 0, 0},
    '{8'hfe, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0}, '{8'hff, 0, 0, 0},
    '{8'hc3, 0, 0, 0}, '{8'h3c, 0, 0, 0},
    // Skipped block type, then an empty PCM block
    '{8'h67, 0, 0, 0}, '{8'h66, 0, 0, 0}, '{8'h40, 0, 0, 0}, '{8'h02, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'hde, 0, 0, 0}, '{8'had, 0, 0, 0},
    '{8'h67, 0, 0, 0}, '{8'h66, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0},
    '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}, '{8'h00, 0, 0, 0}
  };

  initial begin
    logic [7:0] op;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.stream_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    res_if.ready = 1'b0;
    errs = 0;
    stall_cycles = 0;
    src_idle = 26;
    snk_idle = 57;
    cfg_loop = 1'b0;
    cfg_limit = '0;
    op_cur = '0;
    byte_cnt = '0;
    opnd = '0;
    blk_type = '0;
    blk_rem = '0;
    rom_start = '0;
    preset_62 = WAIT_NTSC_RST;
    preset_63 = WAIT_PAL_RST;
    loops = '0;
    halted = 1'b0;
    wr_ptr = '0;
    rd_ptr = '0;
    pcm_hi = -1;
    foreach (pcm_ok[i]) pcm_ok[i] = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Loop forever on end markers
    cfg_write(CFG_LOOP_ENABLED, 8'd1);
    cfg_write(CFG_REPEAT_LIMIT, 8'd0);
    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].chk, dir_tab[i].k, dir_tab[i].w);
    repeat (45) gen_cmd(1'b1);
    drain();

    // Highest limit; swap the idling sides
    src_idle = 57;
    snk_idle = 26;
    cfg_write(CFG_REPEAT_LIMIT, 8'd255);
    repeat (45) gen_cmd(1'b1);
    drain();

    // No loop point: end markers would stop the run, so hold them back
    src_idle = 0;
    snk_idle = 0;
    cfg_write(CFG_LOOP_ENABLED, 8'd0);
    cfg_write(CFG_REPEAT_LIMIT, 8'($urandom_range(1, 254)));
    repeat (40) gen_cmd(1'b0);
    drain();

    // One halting command closes the stream; later bytes are dropped
    case ($urandom_range(0, 4))
      0: send_byte(OP_END);
      1: begin
        cfg_write(CFG_LOOP_ENABLED, 8'd1);
        cfg_write(CFG_REPEAT_LIMIT, loops + 8'd1);
        send_byte(OP_END);
      end
      2: begin
        do op = 8'($urandom_range(0, 255)); while (cmd_len(op) >= 0);
        send_byte(op);
      end
      3: begin
        do op = 8'($urandom_range(0, 255)); while (op == 8'h62 || op == 8'h63);
        send_byte(OP_WAIT_PRESET);
        send_byte(op);
        send_rand(2);
      end
      default: data_block(8'($urandom_range(8'h80, 8'hbf)), $urandom_range(0, 7));
    endcase
    send_rand(4);
    send_byte(OP_WAIT_NTSC);
    drain();

    if (errs == 0) begin
      $display("tb_vgm_command_stream_decoder: done, clean");
    end else begin
      $display("tb_vgm_command_stream_decoder: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/vcsd_pkg.sv
rtl/vcsd_byte_if.sv
rtl/vcsd_res_if.sv
rtl/vcsd_cfg_if.sv
rtl/vcsd_decoder.sv
rtl/vcsd_emitter.sv
rtl/vcsd_command_stream_decoder.sv
tb/tb_vgm_command_stream_decoder.sv
